@@ rtl/aps_pkg.sv @@
// Package: shared types and constants for the aging priority scheduler.
package aps_pkg;

	localparam int TASK_SLOTS = 64;
	localparam int AGE_BITS   = 16;
	localparam int SLOT_W     = 6;
	localparam int ID_W       = 15;
	localparam int PRIO_W     = 3;
	localparam int SLEEP_W    = 16;
	localparam int RATIO_W    = 8;
	localparam int SLICE_W    = 16;
	localparam int SCORE_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] OP_SCHED = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PRIO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE    = 2'd2;

	typedef struct packed {
		logic                used;
		logic                blk;
		logic [PRIO_W-1:0]   prio;
		logic [SLEEP_W-1:0]  sleep;
		logic [AGE_BITS-1:0] age;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		logic              shift;
		logic              clear_win;
		logic [SLOT_W-1:0] win_slot;
		logic [PRIO_W-1:0] max_prio;
	} cell_ctl_t;

endpackage

@@ rtl/aging_priority_scheduler_top.sv @@
// Top level: aging priority scheduler over a rotating chain of task cells.
// A schedule request rotates the 64-entry table once through a chain of cells,
// one slot per cycle; the slot at the head is aged or woken and scored
// (registered multiply, then compare). The request passes through the scan state,
// the drain state that empties the scoring pipeline, and the done state that picks
// the winner, clears its age and registers the result. An empty table and all other
// requests (write-slot, tick, reserved) give their result the cycle after acceptance.
// One request is worked at a time; the result is held in an output register and the
// next request is taken the cycle after that result leaves.
module aging_priority_scheduler_top
	import aps_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_idx,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [SLOT_W-1:0]             slot,
	input  logic [ID_W-1:0]               task_id,
	input  logic [PRIO_W-1:0]             prio,
	input  logic signed [SLEEP_W-1:0]     sleep_count,
	input  logic                          is_blocked,
	input  logic                          in_use,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SLOT_W-1:0]             chosen_slot,
	output logic [ID_W-1:0]               chosen_id,
	output logic                          idle_chosen,
	output logic                          slice_expired
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [PRIO_W-1:0]   max_prio_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic [SLICE_W-1:0]  slice_len_q;
	logic [SLICE_W-1:0]  slice_left_q;
	logic [SLOT_W:0]     cnt_q;
	logic [1:0]          drain_q;

	entry_t    cells [TASK_SLOTS];
	cell_ctl_t ctl;
	entry_t    load_entry;
	logic      accept;

	// scoring pipeline
	logic                 v_s1, v_s2;
	logic [SLOT_W-1:0]    slot_s1, slot_s2;
	logic [ID_W-1:0]      id_s1, id_s2;
	logic signed [PRIO_W+1:0] dist_s1;
	logic [AGE_BITS-1:0]  age_s1, age_s2;
	logic signed [SCORE_W-1:0] prod_s2;
	logic signed [AGE_BITS+SCORE_W:0] score;
	logic signed [AGE_BITS+SCORE_W:0] best_q;
	logic                 found_q;
	logic [SLOT_W-1:0]    win_q;
	logic [ID_W-1:0]      win_id_q;
	logic                 any_used;
	entry_t               head_new;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_comb begin
		any_used = 1'b0;
		for (int i = 0; i < TASK_SLOTS; i++) any_used = any_used | cells[i].used;
	end

	assign ctl.shift     = (state_q == ST_SCAN);
	assign ctl.clear_win = (state_q == ST_DONE) && found_q;
	assign ctl.win_slot  = win_q;
	assign ctl.max_prio  = max_prio_q;

	assign load_entry = '{used: in_use, blk: is_blocked, prio: prio, sleep: sleep_count,
		age: '0, id: task_id};

	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		aps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.idx        (SLOT_W'(g)),
			.load       (accept && op == OP_WRITE && slot == SLOT_W'(g)),
			.load_entry (load_entry),
			.prev       (cells[(g + 1) % TASK_SLOTS]),
			.is_head    (g == TASK_SLOTS - 1),
			.entry      (cells[g])
		);
	end

	// slot 0 exits at cell 0 into the last cell; last cell receives updated head
	assign head_new = cells[TASK_SLOTS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN) && cells[0].used && !cells[0].sleep[SLEEP_W-1]
				&& !cells[0].blk;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= cnt_q[SLOT_W-1:0];
		id_s1   <= cells[0].id;
		dist_s1 <= $signed({2'b00, max_prio_q}) - $signed({2'b00, cells[0].prio});
		age_s1  <= (cells[0].age == {AGE_BITS{1'b1}}) ? cells[0].age : cells[0].age + 1'b1;
		slot_s2 <= slot_s1;
		id_s2   <= id_s1;
		age_s2  <= age_s1;
		prod_s2 <= SCORE_W'(dist_s1 * $signed({1'b0, ratio_q}));
	end

	assign score = (AGE_BITS+SCORE_W+1)'(prod_s2) + $signed({{(SCORE_W+1){1'b0}}, age_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_prio_q    <= 3'd4;
			ratio_q       <= 8'd10;
			slice_len_q   <= 16'd10;
			slice_left_q  <= 16'd10;
			cnt_q         <= '0;
			drain_q       <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			win_q         <= '0;
			win_id_q      <= '0;
			out_valid     <= 1'b0;
			chosen_slot   <= '0;
			chosen_id     <= '0;
			idle_chosen   <= 1'b0;
			slice_expired <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MAX_PRIO: max_prio_q  <= cfg_data[PRIO_W-1:0];
					REG_RATIO:    ratio_q     <= cfg_data[RATIO_W-1:0];
					REG_SLICE:    slice_len_q <= cfg_data[SLICE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						chosen_slot   <= '0;
						chosen_id     <= '0;
						idle_chosen   <= 1'b0;
						slice_expired <= 1'b0;
						if (op == OP_SCHED) begin
							slice_left_q <= slice_len_q;
							found_q      <= 1'b0;
							if (any_used) begin
								cnt_q   <= '0;
								state_q <= ST_SCAN;
							end else begin
								idle_chosen <= 1'b1;
								out_valid   <= 1'b1;
							end
						end else begin
							if (op == OP_TICK) begin
								slice_left_q  <= slice_left_q - 1'b1;
								slice_expired <= (slice_left_q == 16'd1);
							end
							out_valid <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(TASK_SLOTS - 1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd1) state_q <= ST_DONE;
				end
				ST_DONE: begin
					chosen_slot <= found_q ? win_q : '0;
					chosen_id   <= found_q ? win_id_q : '0;
					idle_chosen <= !found_q;
					out_valid   <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_s2 && score >= 0 && (!found_q || score > best_q)) begin
				found_q  <= 1'b1;
				best_q   <= score;
				win_q    <= slot_s2;
				win_id_q <= id_s2;
			end
		end
	end

	logic unused_ok;
	assign unused_ok = head_new.used & ctl.max_prio[0];

endmodule

@@ rtl/aps_cell.sv @@
// One table slot in the rotating chain; updates the entry as it leaves the head.
module aps_cell
	import aps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [SLOT_W-1:0] idx,
	input  logic              load,
	input  entry_t            load_entry,
	input  entry_t            prev,
	input  logic              is_head,
	output entry_t            entry
);

	entry_t entry_q;
	entry_t upd;

	always_comb begin
		upd = prev;
		if (is_head && prev.used) begin
			if (prev.sleep[SLEEP_W-1]) begin
				upd.sleep = prev.sleep + 1'b1;
			end else if (!prev.blk) begin
				if (prev.age != {AGE_BITS{1'b1}}) upd.age = prev.age + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (load) begin
			entry_q <= load_entry;
		end else if (ctl.shift) begin
			entry_q <= upd;
		end else if (ctl.clear_win && ctl.win_slot == idx) begin
			entry_q.age <= '0;
		end
	end

	assign entry = entry_q;

endmodule

@@ verif/aging_priority_scheduler_checker.sv @@
// Checker: models the aging priority scheduler, compares every result with its prediction.
module aging_priority_scheduler_checker
	import aps_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_idx,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                op,
	input  logic [SLOT_W-1:0]         slot,
	input  logic [ID_W-1:0]           task_id,
	input  logic [PRIO_W-1:0]         prio,
	input  logic signed [SLEEP_W-1:0] sleep_count,
	input  logic                      is_blocked,
	input  logic                      in_use,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [SLOT_W-1:0]         chosen_slot,
	input  logic [ID_W-1:0]           chosen_id,
	input  logic                      idle_chosen,
	input  logic                      slice_expired,
	output int                        fail_count,
	output int                        pending,
	output int                        sched_count,
	output int                        idle_count,
	output int                        expiry_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic              idle;
		logic              expired;
	} decision_t;

	entry_t              tbl [TASK_SLOTS];
	logic [PRIO_W-1:0]   cur_max_prio;
	logic [RATIO_W-1:0]  cur_ratio;
	logic [SLICE_W-1:0]  cur_slice_len;
	logic [SLICE_W-1:0]  slice_left;
	decision_t           decisions [$];

	function automatic decision_t pick_task();
		decision_t d;
		int best;
		int winner;
		int score;
		bit any_used;
		d = '0;
		best = -1;
		winner = -1;
		any_used = 0;
		slice_left = cur_slice_len;
		foreach (tbl[i]) any_used |= tbl[i].used;
		if (any_used) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (!tbl[i].used) continue;
				if (tbl[i].sleep[SLEEP_W-1]) begin
					tbl[i].sleep = tbl[i].sleep + 1'b1;
					continue;
				end
				if (tbl[i].blk) continue;
				if (tbl[i].age != '1) tbl[i].age = tbl[i].age + 1'b1;
				score = (int'(cur_max_prio) - int'(tbl[i].prio)) * int'(cur_ratio)
					+ int'(tbl[i].age);
				if (score > best) begin
					best = score;
					winner = i;
				end
			end
		end
		if (winner >= 0) begin
			tbl[winner].age = '0;
			d.slot = winner[SLOT_W-1:0];
			d.id = tbl[winner].id;
		end else begin
			d.idle = 1'b1;
		end
		return d;
	endfunction

	assign pending = decisions.size();

	always @(posedge clk or negedge arst_n) begin
		decision_t d;
		decision_t got;
		if (!arst_n) begin
			foreach (tbl[i]) tbl[i] = '0;
			cur_max_prio = 3'd4;
			cur_ratio = 8'd10;
			cur_slice_len = 16'd10;
			slice_left = 16'd10;
			decisions.delete();
			fail_count = 0;
			sched_count = 0;
			idle_count = 0;
			expiry_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MAX_PRIO: cur_max_prio = cfg_data[PRIO_W-1:0];
					REG_RATIO: cur_ratio = cfg_data[RATIO_W-1:0];
					REG_SLICE: cur_slice_len = cfg_data[SLICE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				d = '0;
				case (op)
					OP_SCHED: begin
						d = pick_task();
						sched_count++;
						if (d.idle) idle_count++;
					end
					OP_WRITE: begin
						tbl[slot] = '{used: in_use, blk: is_blocked, prio: prio,
							sleep: sleep_count, age: '0, id: task_id};
					end
					OP_TICK: begin
						slice_left = slice_left - 1'b1;
						d.expired = (slice_left == '0);
						if (d.expired) expiry_count++;
					end
					default: ;
				endcase
				decisions.push_back(d);
			end
			if (out_valid && out_ready) begin
				got = '{chosen_slot, chosen_id, idle_chosen, slice_expired};
				if (decisions.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, got);
					fail_count++;
				end else begin
					d = decisions.pop_front();
					if (got.slot !== d.slot) begin
						$display("%0t: chosen_slot expected %0d actual %0d", $time, d.slot, got.slot);
						fail_count++;
					end
					if (got.id !== d.id) begin
						$display("%0t: chosen_id expected %0d actual %0d", $time, d.id, got.id);
						fail_count++;
					end
					if (got.idle !== d.idle) begin
						$display("%0t: idle_chosen expected %0b actual %0b", $time, d.idle, got.idle);
						fail_count++;
					end
					if (got.expired !== d.expired) begin
						$display("%0t: slice_expired expected %0b actual %0b", $time, d.expired,
							got.expired);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

@@ verif/aging_priority_scheduler_top_tb.sv @@
// Testbench top: drives requests and register writes into the scheduler and reports the verdict.
module aging_priority_scheduler_top_tb;
	import aps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 200;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_idx;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                op;
	logic [SLOT_W-1:0]         slot;
	logic [ID_W-1:0]           task_id;
	logic [PRIO_W-1:0]         prio;
	logic signed [SLEEP_W-1:0] sleep_count;
	logic                      is_blocked;
	logic                      in_use;
	logic                      out_valid;
	logic                      out_ready;
	logic [SLOT_W-1:0]         chosen_slot;
	logic [ID_W-1:0]           chosen_id;
	logic                      idle_chosen;
	logic                      slice_expired;
	int                        fail_count;
	int                        pending;
	int                        sched_count;
	int                        idle_count;
	int                        expiry_count;
	bit                        calm;
	bit                        hold_sink;
	int                        quiet = 0;
	int                        n_requests;

	aging_priority_scheduler_top DUT (.*);

	aging_priority_scheduler_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// watchdog: cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int n;
		bit held;
		out_ready = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink && !held) begin
				out_ready <= 0;
				repeat (600) @(posedge clk);
				held = 1;
			end else if (!calm && $urandom_range(3) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 7);
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1;
				@(posedge clk);
			end
		end
	end

	task automatic send(input logic [1:0] o, input int s, input int id, input int p,
		input int slp, input bit b, input bit u);
		int n;
		if (!calm && $urandom_range(4) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 7);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		slot <= SLOT_W'(s);
		task_id <= ID_W'(id);
		prio <= PRIO_W'(p);
		sleep_count <= SLEEP_W'(slp);
		is_blocked <= b;
		in_use <= u;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_requests++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic rand_write();
		int slp;
		case ($urandom_range(3))
			0: slp = -$urandom_range(1, 5);
			1: slp = -$urandom_range(1, 32767);
			2: slp = $urandom_range(0, 32767);
			default: slp = 0;
		endcase
		if ($urandom_range(9) == 0) slp = 16'h8000;
		send(OP_WRITE, $urandom_range(63), $urandom_range(32767), $urandom_range(7), slp,
			$urandom_range(3) == 0, $urandom_range(4) != 0);
	endtask

	task automatic rand_request();
		int k;
		k = $urandom_range(9);
		if (k < 4) rand_write();
		else if (k < 7) send(OP_SCHED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else if (k < 9) send(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else send(OP_RSVD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 0;
		op = '0;
		slot = '0;
		task_id = '0;
		prio = '0;
		sleep_count = '0;
		is_blocked = 0;
		in_use = 0;
		calm = 0;
		hold_sink = 0;
		n_requests = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, ticks through expiry and wrap
		send(OP_SCHED, 0, 0, 0, 0, 0, 0);
		repeat (11) send(OP_TICK, 0, 0, 0, 0, 0, 0);
		send(OP_WRITE, 0, 32767, 0, 0, 0, 1);
		send(OP_WRITE, 63, 1, 7, 0, 0, 1);
		send(OP_WRITE, 5, 12345, 2, -2, 0, 1);
		send(OP_WRITE, 6, 777, 1, 0, 1, 1);
		send(OP_WRITE, 7, 21845, 3, 32767, 0, 1);
		send(OP_WRITE, 8, 10922, 4, -32767, 0, 1);
		repeat (4) send(OP_SCHED, 0, 0, 0, 0, 0, 0);
		send(OP_RSVD, 63, 32767, 7, -1, 1, 1);
		send(OP_WRITE, 0, 0, 0, 0, 0, 0);
		send(OP_SCHED, 0, 0, 0, 0, 0, 0);
		drain();

		// register settings: extremes and random
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_MAX_PRIO, 0); write_reg(REG_RATIO, 255);
					write_reg(REG_SLICE, 1); end
				1: begin write_reg(REG_MAX_PRIO, 7); write_reg(REG_RATIO, 0);
					write_reg(REG_SLICE, 65535); end
				2: begin write_reg(REG_MAX_PRIO, 7); write_reg(REG_RATIO, 255);
					write_reg(REG_SLICE, 3); end
				default: begin write_reg(REG_MAX_PRIO, $urandom_range(7));
					write_reg(REG_RATIO, $urandom_range(255));
					write_reg(REG_SLICE, $urandom_range(1, 20)); end
			endcase
			if (ph == 1) hold_sink = 1;
			repeat (140) rand_request();
			drain();
		end
		// long aging run with no idling
		calm = 1;
		write_reg(REG_MAX_PRIO, 4);
		write_reg(REG_RATIO, 1);
		repeat (40) rand_write();
		repeat (50) send(OP_SCHED, 0, 0, 0, 0, 0, 0);
		drain();
		repeat (DRAIN) @(posedge clk);
		$display("Ran %0d requests: %0d schedules (%0d idle), %0d slice expiries.",
			n_requests, sched_count, idle_count, expiry_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
